[rtl/pvh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_pkg
// Shared types, widths and constants of the three-axis PID velocity and
// heading controller.
// ----------------------------------------------------------------------------
package pvh_pkg;

	// Field widths of the stream items and registers.
	localparam int POS_W   = 31;
	localparam int ERR_W   = 32;
	localparam int DT_W    = 16;
	localparam int YAW_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int VEL_W   = 32;
	localparam int HEAD_W  = 16;

	// Packing of the input and output items.
	localparam int DT_LSB  = 6 * POS_W;
	localparam int YAW_LSB = DT_LSB + DT_W;
	localparam int IN_W    = YAW_LSB + YAW_W;
	localparam int IN_BUS_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W   = 3 * VEL_W + HEAD_W;
	localparam int OUT_BUS_W = ((OUT_W + 7) / 8) * 8;

	// Datapath widths.
	localparam int MAG_W   = 64;
	localparam int ACC_W   = 64;
	localparam int DIVN_W  = 48;
	localparam int MULA_W  = 16;
	localparam int MULB_W  = 32;
	localparam int MULP_W  = MULA_W + MULB_W;
	localparam int CORD_W  = 36;
	localparam int ANG_W   = 24;
	localparam int HANG_W  = 26;
	localparam int TIME_FRAC = 16;
	localparam int GAIN_FRAC = 8;
	localparam int ATAN_LEN  = 24;

	// Default parameter values.
	localparam int INTEG_WIDTH_DEF  = 48;
	localparam int CORDIC_STEPS_DEF = 16;

	// Quarter turn in Q.20 radians.
	localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 24'sd1647099;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_GAIN_P = 2'd0;
	localparam logic [1:0] REG_GAIN_I = 2'd1;
	localparam logic [1:0] REG_GAIN_D = 2'd2;
	localparam logic [1:0] REG_GAIN_H = 2'd3;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_INT_MUL,
		ST_INT_ADD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_TERM_LO,
		ST_TERM_HI,
		ST_TERM_SAT,
		ST_TERM_ACC,
		ST_VEL,
		ST_COR_PRE,
		ST_COR_IT,
		ST_HEAD_MUL,
		ST_HEAD_OUT,
		ST_HOLD
	} pvh_state_t;

	// Status of the serial divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Arctangent of 2^-i in Q.20 radians.
	function automatic logic signed [ANG_W-1:0] atan_q20(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		unique case (idx)
			5'd0:  v = 24'sd823550;
			5'd1:  v = 24'sd486170;
			5'd2:  v = 24'sd256879;
			5'd3:  v = 24'sd130396;
			5'd4:  v = 24'sd65451;
			5'd5:  v = 24'sd32757;
			5'd6:  v = 24'sd16383;
			5'd7:  v = 24'sd8192;
			5'd8:  v = 24'sd4096;
			5'd9:  v = 24'sd2048;
			5'd10: v = 24'sd1024;
			5'd11: v = 24'sd512;
			5'd12: v = 24'sd256;
			5'd13: v = 24'sd128;
			5'd14: v = 24'sd64;
			5'd15: v = 24'sd32;
			5'd16: v = 24'sd16;
			5'd17: v = 24'sd8;
			5'd18: v = 24'sd4;
			5'd19: v = 24'sd2;
			5'd20: v = 24'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[rtl/pvh_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_div
// Restoring divider of an unsigned numerator by the time step, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module pvh_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pvh_pkg::DIVN_W-1:0]  num,
	input  wire logic [pvh_pkg::DT_W-1:0]    den,
	output logic      [pvh_pkg::DIVN_W-1:0]  quot,
	output pvh_pkg::div_stat_t               stat
);
	import pvh_pkg::*;

	localparam int CNT_W = $clog2(DIVN_W);

	logic [DIVN_W-1:0] q_q;
	logic [DT_W-1:0]   rem_q;
	logic [DT_W-1:0]   den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DT_W:0]     trial;
	logic              ge;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, q_q[DIVN_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVN_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DT_W'(trial - {1'b0, den_q}) : DT_W'(trial);
			q_q   <= {q_q[DIVN_W-2:0], ge};
		end
	end

	assign quot = q_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule
`default_nettype wire

[rtl/three_axis_pid_velocity_heading.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_pid_velocity_heading
// Three-axis PID position-to-velocity controller with a CORDIC heading
// command, built around one shared 16x32 multiplier and a small sequencer.
// ----------------------------------------------------------------------------
// One item is processed at a time. Per axis the sequencer works through the
// error and integrator, the serial derivative division (skipped when the time
// step is zero), the three gain products through the shared multiplier and the
// velocity saturation; the heading then runs the CORDIC steps (skipped when
// both velocities are zero). The input is ready again in the cycle the result
// appears. The result sits in an output register, so the next item is taken
// while it waits. Gains are to be written on the cfg port while the block is
// idle; the block itself does not enforce this.
module three_axis_pid_velocity_heading #(
	parameter int INTEG_WIDTH  = pvh_pkg::INTEG_WIDTH_DEF,
	parameter int CORDIC_STEPS = pvh_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// want_x, want_y, want_z, meas_x, meas_y, meas_z, time_step, yaw_rate
	input  wire logic [pvh_pkg::IN_BUS_W-1:0]  s_axis_tdata,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// vel_x, vel_y, vel_z, heading_cmd
	output logic      [pvh_pkg::OUT_BUS_W-1:0] m_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [pvh_pkg::GAIN_W-1:0]    cfg_data
);
	import pvh_pkg::*;

	localparam int IW  = INTEG_WIDTH;
	localparam int CIW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	pvh_state_t state_q, next_st;

	logic [IN_W-1:0]                 in_q;
	logic signed [GAIN_W-1:0]        gain_p_q, gain_i_q, gain_d_q, gain_h_q;
	logic signed [IW-1:0]            integ_q [3];
	logic signed [ERR_W-1:0]         last_q [3];
	logic signed [VEL_W-1:0]         vel_q [3];
	logic [1:0]                      axis_q, term_q;
	logic signed [ERR_W-1:0]         e_q;
	logic [DIVN_W-1:0]               dnum_q, dmag_q;
	logic                            dneg_q;
	logic [MULP_W-1:0]               mul_q, lo_q;
	logic signed [ACC_W-1:0]         p_q, acc_q;
	logic signed [CORD_W-1:0]        cx_q, cy_q;
	logic signed [ANG_W-1:0]         cz_q;
	logic [CIW-1:0]                  step_q;
	logic signed [HEAD_W-1:0]        head_q;
	logic [OUT_W-1:0]                out_q;
	logic                            out_valid_q;

	logic [MULA_W-1:0]               mul_a;
	logic [MULB_W-1:0]               mul_b;
	logic                            div_start;
	logic [DIVN_W-1:0]               div_quot;
	div_stat_t                       div_st;

	logic signed [POS_W-1:0]         want_cur, meas_cur;
	logic signed [ERR_W-1:0]         e_cur;
	logic signed [ERR_W:0]           diff;
	logic [ERR_W:0]                  dabs;
	logic [DT_W-1:0]                 dt;
	logic signed [YAW_W-1:0]         yaw;
	logic [ERR_W-1:0]                e_mag;
	logic signed [GAIN_W-1:0]        g_cur;
	logic [GAIN_W-1:0]               g_mag;
	logic                            x_neg;
	logic [MAG_W-1:0]                x_mag;
	logic [IW-1:0]                   i_mag;
	logic signed [MULP_W:0]          int_prod;
	logic signed [MULP_W-TIME_FRAC:0] int_inc;
	logic signed [IW:0]              int_sum;
	logic signed [IW-1:0]            int_sat;
	logic [79:0]                     m80;
	logic signed [ACC_W-1:0]         p_sat;
	logic signed [ACC_W:0]           acc_sum;
	logic signed [ACC_W-1:0]         acc_sat;
	logic signed [ACC_W-GAIN_FRAC-1:0] acc_sh;
	logic signed [VEL_W-1:0]         vel_sat;
	logic signed [CORD_W-1:0]        vx, vy, dxs, dys;
	logic signed [ANG_W-1:0]         atan_i;
	logic signed [HANG_W-1:0]        ang;
	logic [HANG_W-1:0]               ang_mag;
	logic [GAIN_W-1:0]               gh_mag;
	logic signed [MULP_W:0]          h_prod;
	logic signed [MULP_W-15+1:0]     h_sh;
	logic signed [HEAD_W-1:0]        h_sat;
	logic                            out_free;

	// Serial divider for the derivative term.
	pvh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dnum_q),
		.den    (dt),
		.quot   (div_quot),
		.stat   (div_st)
	);

	// Field selection for the current axis.
	always_comb begin
		dt  = in_q[DT_LSB +: DT_W];
		yaw = in_q[YAW_LSB +: YAW_W];
		case (axis_q)
			2'd1: begin
				want_cur = in_q[POS_W +: POS_W];
				meas_cur = in_q[4*POS_W +: POS_W];
			end
			2'd2: begin
				want_cur = in_q[2*POS_W +: POS_W];
				meas_cur = in_q[5*POS_W +: POS_W];
			end
			default: begin
				want_cur = in_q[0 +: POS_W];
				meas_cur = in_q[3*POS_W +: POS_W];
			end
		endcase
		e_cur = ERR_W'(want_cur) - ERR_W'(meas_cur);
		diff  = (ERR_W+1)'(e_cur) - (ERR_W+1)'(last_q[axis_q]);
		dabs  = diff[ERR_W] ? -diff : diff;
		e_mag = e_q[ERR_W-1] ? -e_q : e_q;
	end

	// Integrator update with saturation at the integrator bounds.
	always_comb begin
		int_prod = e_q[ERR_W-1] ? -$signed({1'b0, mul_q}) : $signed({1'b0, mul_q});
		int_inc  = int_prod[MULP_W:TIME_FRAC];
		int_sum  = (IW+1)'(integ_q[axis_q]) + (IW+1)'(int_inc);
		if (int_sum[IW] != int_sum[IW-1])
			int_sat = int_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		else
			int_sat = int_sum[IW-1:0];
	end

	// Gain and operand of the current PID term.
	always_comb begin
		i_mag = integ_q[axis_q][IW-1] ? -integ_q[axis_q] : integ_q[axis_q];
		case (term_q)
			2'd1: begin
				g_cur = gain_i_q;
				x_neg = integ_q[axis_q][IW-1];
				x_mag = MAG_W'(i_mag);
			end
			2'd2: begin
				g_cur = gain_d_q;
				x_neg = dneg_q;
				x_mag = MAG_W'(dmag_q);
			end
			default: begin
				g_cur = gain_p_q;
				x_neg = e_q[ERR_W-1];
				x_mag = MAG_W'(e_mag);
			end
		endcase
		g_mag = g_cur[GAIN_W-1] ? -g_cur : g_cur;
	end

	// Product assembly, saturating accumulation and velocity saturation.
	always_comb begin
		m80 = {mul_q, 32'b0} + 80'(lo_q);
		if (m80[79:63] != '0)
			p_sat = (g_cur[GAIN_W-1] ^ x_neg) ? {1'b1, {(ACC_W-1){1'b0}}}
				: {1'b0, {(ACC_W-1){1'b1}}};
		else
			p_sat = (g_cur[GAIN_W-1] ^ x_neg) ? -$signed(m80[63:0]) : $signed(m80[63:0]);
		acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(p_q);
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
			acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			acc_sat = acc_sum[ACC_W-1:0];
		acc_sh = acc_q[ACC_W-1:GAIN_FRAC];
		if (acc_sh > (ACC_W-GAIN_FRAC)'(32'sh7fffffff))
			vel_sat = 32'sh7fffffff;
		else if (acc_sh < -(ACC_W-GAIN_FRAC)'(33'sh080000000))
			vel_sat = {1'b1, 31'b0};
		else
			vel_sat = acc_sh[VEL_W-1:0];
	end

	// CORDIC step and heading arithmetic.
	always_comb begin
		vx     = CORD_W'(vel_q[0]);
		vy     = CORD_W'(vel_q[1]);
		dxs    = cy_q >>> step_q;
		dys    = cx_q >>> step_q;
		atan_i = atan_q20(5'(step_q));
		ang    = HANG_W'(cz_q) - HANG_W'(HALF_PI_Q20) - (HANG_W'(yaw) <<< 7);
		ang_mag = ang[HANG_W-1] ? -ang : ang;
		gh_mag = gain_h_q[GAIN_W-1] ? -gain_h_q : gain_h_q;
		h_prod = (ang[HANG_W-1] ^ gain_h_q[GAIN_W-1]) ? -$signed({1'b0, mul_q})
			: $signed({1'b0, mul_q});
		h_sh   = (MULP_W-13)'((h_prod + (MULP_W+1)'(1 << 14)) >>> 15);
		if (h_sh > 35'sd32767)
			h_sat = 16'sh7fff;
		else if (h_sh < -35'sd32768)
			h_sat = 16'sh8000;
		else
			h_sat = h_sh[HEAD_W-1:0];
	end

	// Next-state logic of the sequencer.
	always_comb begin
		next_st = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_axis_tvalid) next_st = ST_ERR;
			ST_ERR:      next_st = ST_INT_MUL;
			ST_INT_MUL:  next_st = ST_INT_ADD;
			ST_INT_ADD:  next_st = ST_DIV_GO;
			ST_DIV_GO:   next_st = (dt == '0) ? ST_TERM_LO : ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_st.done) next_st = ST_TERM_LO;
			ST_TERM_LO:  next_st = ST_TERM_HI;
			ST_TERM_HI:  next_st = ST_TERM_SAT;
			ST_TERM_SAT: next_st = ST_TERM_ACC;
			ST_TERM_ACC: next_st = (term_q == 2'd2) ? ST_VEL : ST_TERM_LO;
			ST_VEL:      next_st = (axis_q == 2'd2) ? ST_COR_PRE : ST_ERR;
			ST_COR_PRE:  next_st = (vel_q[0] == '0 && vel_q[1] == '0) ? ST_HEAD_MUL
				: ST_COR_IT;
			ST_COR_IT:   if (step_q == CIW'(CORDIC_STEPS - 1)) next_st = ST_HEAD_MUL;
			ST_HEAD_MUL: next_st = ST_HEAD_OUT;
			ST_HEAD_OUT: next_st = ST_HOLD;
			ST_HOLD:     if (out_free) next_st = ST_IDLE;
			default:     next_st = ST_IDLE;
		endcase
	end

	// Multiplier operands and divider start for each state.
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		unique case (state_q)
			ST_INT_MUL: begin
				mul_a = dt;
				mul_b = e_mag;
			end
			ST_TERM_LO: begin
				mul_a = g_mag;
				mul_b = x_mag[31:0];
			end
			ST_TERM_HI: begin
				mul_a = g_mag;
				mul_b = x_mag[63:32];
			end
			ST_HEAD_MUL: begin
				mul_a = gh_mag;
				mul_b = MULB_W'(ang_mag);
			end
			ST_DIV_GO:   div_start = (dt != '0);
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;

	// Control registers: state, counters, gains, integrators, last errors and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			term_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			gain_p_q    <= 16'sd256;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			gain_h_q    <= 16'sd256;
			for (int k = 0; k < 3; k++) begin
				integ_q[k] <= '0;
				last_q[k]  <= '0;
			end
		end else begin
			state_q <= next_st;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GAIN_P: gain_p_q <= cfg_data;
					REG_GAIN_I: gain_i_q <= cfg_data;
					REG_GAIN_D: gain_d_q <= cfg_data;
					REG_GAIN_H: gain_h_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE:     axis_q <= '0;
				ST_ERR: begin
					last_q[axis_q] <= e_cur;
					term_q         <= '0;
				end
				ST_INT_ADD:  if (dt != '0) integ_q[axis_q] <= int_sat;
				ST_TERM_ACC: term_q <= term_q + 1'b1;
				ST_VEL:      if (axis_q != 2'd2) axis_q <= axis_q + 1'b1;
				ST_COR_PRE:  step_q <= '0;
				ST_COR_IT:   step_q <= step_q + 1'b1;
				default: ;
			endcase
			if (state_q == ST_HOLD && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		mul_q <= MULP_W'(mul_a) * MULP_W'(mul_b);
		if (s_axis_tvalid && s_axis_tready)
			in_q <= s_axis_tdata[IN_W-1:0];
		case (state_q)
			ST_ERR: begin
				e_q    <= e_cur;
				dneg_q <= diff[ERR_W];
				dnum_q <= {dabs[ERR_W-1:0], {TIME_FRAC{1'b0}}};
				acc_q  <= '0;
			end
			ST_DIV_GO:   if (dt == '0) dmag_q <= '0;
			ST_DIV_WAIT: if (div_st.done) dmag_q <= div_quot;
			ST_TERM_HI:  lo_q <= mul_q;
			ST_TERM_SAT: p_q <= p_sat;
			ST_TERM_ACC: acc_q <= acc_sat;
			ST_VEL:      vel_q[axis_q] <= vel_sat;
			ST_COR_PRE: begin
				if (vel_q[0] == '0 && vel_q[1] == '0) begin
					cz_q <= '0;
				end else if (vx < 0) begin
					if (vy >= 0) begin
						cx_q <= vy;
						cy_q <= -vx;
						cz_q <= HALF_PI_Q20;
					end else begin
						cx_q <= -vy;
						cy_q <= vx;
						cz_q <= -HALF_PI_Q20;
					end
				end else begin
					cx_q <= vx;
					cy_q <= vy;
					cz_q <= '0;
				end
			end
			ST_COR_IT: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + dxs;
					cy_q <= cy_q - dys;
					cz_q <= cz_q + atan_i;
				end else begin
					cx_q <= cx_q - dxs;
					cy_q <= cy_q + dys;
					cz_q <= cz_q - atan_i;
				end
			end
			ST_HEAD_OUT: head_q <= h_sat;
			ST_HOLD: if (out_free) out_q <= {head_q, vel_q[2], vel_q[1], vel_q[0]};
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_BUS_W'(out_q);

`ifndef NO_ASSERTIONS
	// The divider only runs while an item is in progress.
	assert property (@(posedge clk) disable iff (!arst_n) s_axis_tready |-> !div_st.busy)
		else $error("divider busy while idle");
	// The axis counter never leaves the three axes.
	assert property (@(posedge clk) disable iff (!arst_n) axis_q != 2'd3)
		else $error("axis counter out of range");
	// An accepted item closes the input until its work is done.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");
`endif

endmodule
`default_nettype wire
